### rtl/assert_macros.svh
// Assertion macros used by the air energy filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/maef_pkg.sv
// Package with types, constants and helpers of the air energy filter.
package maef_pkg;
  localparam int SampleW = 24;
  localparam int AccW = 28;
  localparam int GainW = 16;
  localparam int NumAcc = 44;
  localparam int AccIdxW = 6;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_GAINS_LO = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GAINS_HI = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WET_MIX  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_OVS      = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BAND,
    ST_DUO_A,
    ST_DUO_B,
    ST_RING_RD,
    ST_RING_UPD,
    ST_RING_MUL,
    ST_HALVE,
    ST_BAND_NEXT,
    ST_WET,
    ST_INTERP,
    ST_OUT
  } state_t;

  typedef logic signed [AccW-1:0] acc_t;

  // Base index of band k in the accumulator memory.
  function automatic logic [AccIdxW-1:0] band_base(input logic [3:0] k);
    logic [AccIdxW-1:0] r;
    case (k)
      4'd3: r = 6'd2;
      4'd4: r = 6'd5;
      4'd5: r = 6'd9;
      4'd6: r = 6'd14;
      4'd7: r = 6'd20;
      4'd8: r = 6'd27;
      4'd9: r = 6'd35;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [AccW-1:0] acc_sat(input logic signed [AccW+1:0] v);
    logic signed [AccW+1:0] hi, lo;
    hi = (AccW+2)'((64'sd1 <<< (AccW-1)) - 1);
    lo = -hi - (AccW+2)'(1);
    if (v > hi) return hi[AccW-1:0];
    if (v < lo) return lo[AccW-1:0];
    return v[AccW-1:0];
  endfunction
endpackage

### rtl/maef_mac.sv
// Shared signed multiplier with a registered product.
module maef_mac (
  input  logic                                  clk,
  input  logic signed [maef_pkg::AccW+2:0]      a,
  input  logic signed [maef_pkg::AccW-1:0]      b_in,
  output logic signed [2*maef_pkg::AccW+2:0]    prod_r
);
  import maef_pkg::*;
  logic signed [2*AccW+2:0] prod_nxt;
  always_comb begin
    prod_nxt = (2*AccW+3)'(a) * (2*AccW+3)'(b_in);
  end
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end
endmodule

### rtl/multiband_air_energy_filter_core.sv
// Top level of the multiband air energy filter.
// Usage: one signed Q1.23 word enters on in_sample with in_valid/in_ready and
// one word leaves on out_result_sample with out_valid/out_ready. Every input
// word yields exactly one output word.
// The block works on one word at a time. A word that does not complete an
// oversample period only reads an interpolation point and goes straight to
// the output state, which raises out_valid. A word that completes the period
// runs the active ones of the eight bands through one shared multiplier; a
// ring band walks its ring in the accumulator memory. The wet gain, the
// interpolation and the output step follow the bands.
// After the result is loaded the block returns to idle, where it accepts the
// next word as soon as the receiver takes the result. When the receiver stalls,
// the result holds and in_ready stays low.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once; the
// user makes them only while the block is idle; the block does not enforce it.
// Synchronous active-low reset clears control, configuration and filter state;
// the accumulators are cleared by a pass after reset, with no word accepted.
module multiband_air_energy_filter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [maef_pkg::SampleW-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [maef_pkg::SampleW-1:0]  out_result_sample,
  input  logic                                 cfg_we,
  input  logic [maef_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [maef_pkg::CfgDataW-1:0]        cfg_data
);
  import maef_pkg::*;
`include "assert_macros.svh"

  // Configuration registers.
  logic [63:0] gains_lo_r, gains_hi_r;
  logic signed [16:0] wet_mix_r;
  logic [2:0] ovs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_lo_r <= '0;
      gains_hi_r <= '0;
      wet_mix_r <= 17'sd32768 > 0 ? 17'h08000 : 17'h08000;
      ovs_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAINS_LO: gains_lo_r <= cfg_data;
        REG_GAINS_HI: gains_hi_r <= cfg_data;
        REG_WET_MIX:  wet_mix_r <= cfg_data[16:0];
        REG_OVS:      ovs_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective period 1..4.
  logic [2:0] ce;
  always_comb begin
    if (ovs_r == 3'd0) ce = 3'd1;
    else if (ovs_r > 3'd4) ce = 3'd4;
    else ce = ovs_r;
  end

  // State.
  state_t state_r, state_nxt;
  logic clr_busy_r;
  logic [AccIdxW-1:0] clr_idx_r;
  logic [3:0] band_r;
  logic [3:0] idx_r;
  logic [3:0] phase_r [0:6];
  logic duo_toggle_r;
  logic signed [SampleW-1:0] hist_r [0:7];
  acc_t tap_r [0:7];
  logic [2:0] ophase_r;
  logic signed [SampleW-1:0] x_r;
  logic signed [AccW+9:0] corr_r;
  acc_t cur_r, prev_r, ev_r, od_r;
  acc_t y_r;
  logic out_valid_r;
  logic signed [SampleW-1:0] out_r;

  // Accumulator memory, one write port and one registered read port.
  acc_t mem [0:NumAcc-1];
  logic mem_we;
  logic [AccIdxW-1:0] mem_waddr, mem_raddr;
  acc_t mem_wdata, mem_rdata_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // Shared multiplier.
  logic signed [AccW+2:0] mul_a;
  acc_t mul_b;
  logic signed [2*AccW+2:0] prod_r;
  maef_mac u_mac (.clk(clk), .a(mul_a), .b_in(mul_b), .prod_r(prod_r));

  // Band gain and ring geometry.
  logic signed [GainW-1:0] gain;
  always_comb begin
    case (band_r)
      4'd2: gain = gains_lo_r[15:0];
      4'd3: gain = gains_lo_r[31:16];
      4'd4: gain = gains_lo_r[47:32];
      4'd5: gain = gains_lo_r[63:48];
      4'd6: gain = gains_hi_r[15:0];
      4'd7: gain = gains_hi_r[31:16];
      4'd8: gain = gains_hi_r[47:32];
      default: gain = gains_hi_r[63:48];
    endcase
  end
  logic active;
  assign active = (gain > 16'sd3) || (gain < -16'sd3);

  // The duo band and the end marker have no ring phase.
  logic [2:0] pidx;
  assign pidx = 3'(band_r - 4'd3);
  logic [3:0] ph_eff, cur_i, prev_i;
  always_comb begin
    ph_eff = (pidx == 3'd7) ? 4'd1 : phase_r[pidx];
    if (ph_eff < 4'd1 || ph_eff > band_r) ph_eff = 4'd1;
    cur_i = ph_eff - 4'd1;
    prev_i = (cur_i == 4'd0) ? band_r - 4'd1 : cur_i - 4'd1;
  end
  logic [AccIdxW-1:0] base;
  assign base = band_base(band_r);

  logic signed [SampleW:0] d;
  assign d = (SampleW+1)'(hist_r[3'(band_r - 4'd2)]) - (SampleW+1)'(x_r);

  // Updated previous ring entry; also bypasses the memory when it is entry 0.
  acc_t prev_upd;
  assign prev_upd = acc_sat((AccW+2)'(prev_r) - (AccW+2)'(d));

  // Duo cross leak. The odd entry arrives on the read port in ST_DUO_B.
  acc_t od1, ev1, od2, ev2;
  always_comb begin
    if (duo_toggle_r) begin
      ev1 = acc_sat((AccW+2)'(ev_r) + (AccW+2)'(d));
      od1 = acc_sat((AccW+2)'(mem_rdata_r) - (AccW+2)'(d));
    end else begin
      od1 = acc_sat((AccW+2)'(mem_rdata_r) + (AccW+2)'(d));
      ev1 = acc_sat((AccW+2)'(ev_r) - (AccW+2)'(d));
    end
    od2 = AccW'(((AccW+1)'(od1) - ((AccW+1)'(od1) - (AccW+1)'(ev1) >>> 8)) >>> 1);
    ev2 = AccW'(((AccW+1)'(ev1) - ((AccW+1)'(ev1) - (AccW+1)'(od2) >>> 8)) >>> 1);
  end

  // Wet value and interpolation.
  logic signed [AccW+2:0] wet_full;
  acc_t wet;
  assign wet_full = (AccW+3)'(prod_r >>> 15);
  always_comb begin
    if (prod_r >>> 15 > (2*AccW+3)'((64'sd1 <<< (AccW-1)) - 1))
      wet = {1'b0, {(AccW-1){1'b1}}};
    else if (prod_r >>> 15 < -(2*AccW+3)'(64'sd1 <<< (AccW-1)))
      wet = {1'b1, {(AccW-1){1'b0}}};
    else wet = wet_full[AccW-1:0];
  end

  // Floor division by 3 of a small sum, by reciprocal multiply.
  function automatic acc_t fdiv3(input logic signed [AccW+1:0] v);
    logic signed [AccW+1:0] q;
    logic signed [AccW+1:0] r;
    q = (AccW+2)'(((2*AccW+6)'(v) * (2*AccW+6)'(64'sd5726623061)) >>> 34);
    r = v - q * 3;
    if (r < 0) q = q - 1;
    else if (r >= 3) q = q + 1;
    return q[AccW-1:0];
  endfunction

  logic signed [AccW:0] s0w, s2w;
  acc_t t0n, t1n, t2n, t3n, t4n;
  always_comb begin
    t0n = tap_r[0]; t1n = tap_r[1]; t2n = tap_r[2]; t3n = tap_r[3]; t4n = '0;
    s0w = '0; s2w = '0;
    case (ce)
      3'd4: begin
        t0n = tap_r[4];
        s0w = (AccW+1)'(t0n) + (AccW+1)'(wet);
        t2n = AccW'(s0w >>> 1);
        s2w = (AccW+1)'(t0n) + (AccW+1)'(t2n);
        t1n = AccW'(s2w >>> 1);
        t3n = AccW'(((AccW+1)'(t2n) + (AccW+1)'(wet)) >>> 1);
        t4n = wet;
      end
      3'd3: begin
        t0n = tap_r[3];
        t2n = fdiv3((AccW+2)'(t0n) + (AccW+2)'(t0n) + (AccW+2)'(wet));
        t1n = fdiv3((AccW+2)'(t0n) + (AccW+2)'(wet) + (AccW+2)'(wet));
        t3n = wet;
        t4n = tap_r[4];
      end
      3'd2: begin
        t0n = tap_r[2];
        t1n = AccW'(((AccW+1)'(t0n) + (AccW+1)'(wet)) >>> 1);
        t2n = wet;
        t4n = tap_r[4];
      end
      default: begin
        t0n = wet;
        t4n = tap_r[4];
      end
    endcase
  end

  // Averaging chain and output saturation.
  acc_t y7, y6, y5;
  logic signed [AccW+1:0] osum;
  logic signed [SampleW-1:0] osat;
  always_comb begin
    y7 = (ce >= 3'd4) ? AccW'(((AccW+1)'(y_r) + (AccW+1)'(tap_r[7])) >>> 1) : y_r;
    y6 = (ce >= 3'd3) ? AccW'(((AccW+1)'(y7) + (AccW+1)'(tap_r[6])) >>> 1) : y7;
    y5 = (ce >= 3'd2) ? AccW'(((AccW+1)'(y6) + (AccW+1)'(tap_r[5])) >>> 1) : y6;
    osum = (AccW+2)'(y5) + (AccW+2)'(x_r);
    if (osum > (AccW+2)'(8388607)) osat = 24'sh7fffff;
    else if (osum < -(AccW+2)'(8388608)) osat = 24'sh800000;
    else osat = osum[SampleW-1:0];
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && !clr_busy_r && out_free;
  assign out_valid = out_valid_r;
  assign out_result_sample = out_r;

  logic fire;
  assign fire = in_valid && in_ready;
  logic [2:0] oph_c;
  assign oph_c = (ophase_r > ce - 3'd1) ? ce - 3'd1 : ophase_r;
  logic energy;
  assign energy = (oph_c + 3'd1) == ce;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (fire) state_nxt = energy ? ST_BAND : ST_OUT;
      ST_BAND: begin
        if (band_r == 4'd10) state_nxt = ST_WET;
        else if (!active) state_nxt = ST_BAND_NEXT;
        else if (band_r == 4'd2) state_nxt = ST_DUO_A;
        else state_nxt = ST_RING_RD;
      end
      ST_DUO_A:     state_nxt = ST_DUO_B;
      ST_DUO_B:     state_nxt = ST_RING_MUL;
      ST_RING_RD:   state_nxt = ST_RING_UPD;
      ST_RING_UPD:  state_nxt = ST_RING_MUL;
      ST_RING_MUL:  state_nxt = (band_r == 4'd2) ? ST_BAND_NEXT : ST_HALVE;
      ST_HALVE:     if (idx_r == band_r) state_nxt = ST_BAND_NEXT;
      ST_BAND_NEXT: state_nxt = ST_BAND;
      ST_WET:       state_nxt = ST_INTERP;
      ST_INTERP:    state_nxt = ST_OUT;
      ST_OUT:       state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Memory and multiplier control.
  always_comb begin
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    mul_a = '0; mul_b = '0;
    if (clr_busy_r) begin
      mem_we = 1'b1; mem_waddr = clr_idx_r;
    end
    unique case (state_r)
      ST_BAND:     mem_raddr = (band_r == 4'd2) ? 6'd0 : base + AccIdxW'(cur_i);
      ST_DUO_A:    mem_raddr = 6'd1;
      ST_DUO_B: begin
        mem_we = 1'b1; mem_waddr = 6'd0; mem_wdata = ev2;
      end
      ST_RING_RD:  mem_raddr = base + AccIdxW'(prev_i);
      ST_RING_UPD: begin
        mem_we = 1'b1; mem_waddr = base + AccIdxW'(cur_i);
        mem_wdata = acc_sat((AccW+2)'(cur_r) + (AccW+2)'(d));
      end
      ST_RING_MUL: begin
        mul_a = (AccW+3)'(cur_r); mul_b = AccW'(gain);
        if (band_r == 4'd2) begin
          mem_we = 1'b1; mem_waddr = 6'd1; mem_wdata = od_r;
        end else begin
          mem_we = 1'b1; mem_waddr = base + AccIdxW'(prev_i);
          mem_wdata = prev_upd;
        end
        mem_raddr = base;
      end
      ST_HALVE: begin
        // Entry 0 was read while it was written, so a previous entry at 0
        // takes its new value from the bypass.
        if (idx_r != band_r) mem_raddr = base + AccIdxW'(idx_r);
        mem_we = 1'b1; mem_waddr = base + AccIdxW'(idx_r - 4'd1);
        mem_wdata = (idx_r == 4'd1 && prev_i == 4'd0) ? prev_upd >>> 1
                                                      : mem_rdata_r >>> 1;
      end
      ST_WET: begin
        mul_a = (AccW+3)'(corr_r); mul_b = AccW'(wet_mix_r);
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
      band_r <= 4'd2;
      idx_r <= '0;
      duo_toggle_r <= 1'b0;
      ophase_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 7; i++) phase_r[i] <= 4'd1;
      for (int i = 0; i < 8; i++) begin
        hist_r[i] <= '0;
        tap_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 6'd1;
        if (clr_idx_r == 6'(NumAcc - 1)) clr_busy_r <= 1'b0;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (fire) begin
          x_r <= in_sample;
          ophase_r <= oph_c + 3'd1;
          band_r <= 4'd2;
          corr_r <= '0;
          if (!energy) y_r <= tap_r[oph_c + 3'd1];
        end
        ST_BAND: begin
          idx_r <= '0;
          if (band_r != 4'd2 && band_r != 4'd10 && active) phase_r[pidx] <= ph_eff;
        end
        ST_DUO_A: ev_r <= mem_rdata_r;
        ST_DUO_B: begin
          od_r <= od2;
          cur_r <= duo_toggle_r ? ev1 : od1;
          duo_toggle_r <= !duo_toggle_r;
        end
        ST_RING_RD: cur_r <= mem_rdata_r;
        ST_RING_UPD: begin
          prev_r <= mem_rdata_r;
          cur_r <= acc_sat((AccW+2)'(cur_r) + (AccW+2)'(d));
        end
        ST_RING_MUL: idx_r <= 4'd1;
        ST_HALVE: begin
          idx_r <= idx_r + 4'd1;
          if (idx_r == 4'd1) corr_r <= corr_r + (AccW+10)'(prod_r >>> 15);
          if (idx_r == band_r) phase_r[pidx] <= phase_r[pidx] + 4'd1;
        end
        ST_BAND_NEXT: begin
          if (band_r == 4'd2 && active) corr_r <= corr_r + (AccW+10)'(prod_r >>> 15);
          band_r <= band_r + 4'd1;
        end
        ST_INTERP: begin
          tap_r[0] <= t0n; tap_r[1] <= t1n; tap_r[2] <= t2n;
          tap_r[3] <= t3n; tap_r[4] <= t4n;
          y_r <= t0n;
          ophase_r <= '0;
          for (int i = 7; i > 0; i--) hist_r[i] <= hist_r[i-1];
          hist_r[0] <= x_r;
        end
        ST_OUT: begin
          out_r <= osat;
          out_valid_r <= 1'b1;
          if (ce >= 3'd4) tap_r[7] <= y_r;
          if (ce >= 3'd3) tap_r[6] <= y7;
          if (ce >= 3'd2) tap_r[5] <= y6;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready |-> state_r == ST_IDLE, "ready outside idle")
  `ASSERT_IMPL(a_no_clr_accept, clk, rst_n, clr_busy_r |-> !in_ready, "accept during clear")
  `ASSERT_IMPL(a_out_follows, clk, rst_n, (state_r == ST_OUT) |=> out_valid, "no output word")
endmodule

### test/multiband_air_energy_filter_core_tb.sv
// Self-checking testbench of the multiband air energy filter core.
`timescale 1ns / 100ps

module multiband_air_energy_filter_core_tb;
  import maef_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [SampleW-1:0] in_sample;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [SampleW-1:0] out_result_sample;
  logic                      cfg_we;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [CfgDataW-1:0]       cfg_data;

  // A directed word may carry a result typed in by hand; it then replaces the
  // predicted value in the store of expected results.
  logic                      in_has_typed;
  logic signed [SampleW-1:0] in_typed;

  multiband_air_energy_filter_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_sample(out_result_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // The clock runs with a period of 2 ns.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of all filter state.
  // ---------------------------------------------------------------------
  logic [63:0] gains_lo_q;
  logic [63:0] gains_hi_q;
  longint      mix_q;
  logic [2:0]  ovs_q;
  longint      band_acc[NumAcc];
  int          ring_pos[7];
  bit          duo_flip;
  longint      dry_hist[8];
  longint      taps[9];
  int          ovs_pos;

  logic signed [SampleW-1:0] expected_samples[$];
  int                        errors;

  function automatic longint clip(input longint v, input int w);
    longint lim;
    lim = longint'(1) <<< (w - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Division by three that rounds toward minus infinity.
  function automatic longint third_floor(input longint v);
    if (v >= 0) return v / 3;
    return -((-v + 2) / 3);
  endfunction

  function automatic longint lane_gain(input int k);
    logic signed [15:0] g16;
    if (k <= 5) g16 = gains_lo_q[16*(k-2) +: 16];
    else g16 = gains_hi_q[16*(k-6) +: 16];
    return longint'(g16);
  endfunction

  function automatic void model_clear();
    gains_lo_q = '0;
    gains_hi_q = '0;
    mix_q = 32768;
    ovs_q = 3'd1;
    foreach (band_acc[i]) band_acc[i] = 0;
    foreach (ring_pos[i]) ring_pos[i] = 1;
    duo_flip = 1'b0;
    foreach (dry_hist[i]) dry_hist[i] = 0;
    foreach (taps[i]) taps[i] = 0;
    ovs_pos = 0;
  endfunction

  function automatic void model_write(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] data);
    logic signed [16:0] m17;
    m17 = data[16:0];
    case (idx)
      REG_GAINS_LO: gains_lo_q = data;
      REG_GAINS_HI: gains_hi_q = data;
      REG_WET_MIX:  mix_q = longint'(m17);
      REG_OVS:      ovs_q = data[2:0];
      default: ;
    endcase
  endfunction

  // Runs one dry word through the filter and returns the output word.
  function automatic logic signed [SampleW-1:0] filter_step(
      input logic signed [SampleW-1:0] s);
    longint x, corr, wet, f, d, y, v, g;
    int ce, k, i, base, cur, prv;
    x = longint'(s);
    ce = int'(ovs_q);
    if (ce < 1) ce = 1;
    if (ce > 4) ce = 4;
    // A lowered factor pulls a stale phase back into the new period.
    if (ovs_pos > ce - 1) ovs_pos = ce - 1;
    ovs_pos++;
    if (ovs_pos == ce) begin
      corr = 0;
      g = lane_gain(2);
      if (g > 3 || g < -3) begin
        d = dry_hist[0] - x;
        if (duo_flip) begin
          band_acc[0] = clip(band_acc[0] + d, AccW);
          band_acc[1] = clip(band_acc[1] - d, AccW);
          f = band_acc[0] * g;
        end else begin
          band_acc[1] = clip(band_acc[1] + d, AccW);
          band_acc[0] = clip(band_acc[0] - d, AccW);
          f = band_acc[1] * g;
        end
        // The duo band leaks 1/256 across its pair before halving.
        band_acc[1] = (band_acc[1] - ((band_acc[1] - band_acc[0]) >>> 8)) >>> 1;
        band_acc[0] = (band_acc[0] - ((band_acc[0] - band_acc[1]) >>> 8)) >>> 1;
        corr += f >>> 15;
        duo_flip = !duo_flip;
      end
      for (k = 3; k <= 9; k++) begin
        g = lane_gain(k);
        if (g <= 3 && g >= -3) continue;
        base = k * (k - 1) / 2 - 1;
        if (ring_pos[k-3] < 1 || ring_pos[k-3] > k) ring_pos[k-3] = 1;
        cur = ring_pos[k-3] - 1;
        prv = (cur == 0) ? k - 1 : cur - 1;
        d = dry_hist[k-2] - x;
        band_acc[base+cur] = clip(band_acc[base+cur] + d, AccW);
        band_acc[base+prv] = clip(band_acc[base+prv] - d, AccW);
        f = band_acc[base+cur] * g;
        for (i = 0; i < k; i++) band_acc[base+i] = band_acc[base+i] >>> 1;
        corr += f >>> 15;
        ring_pos[k-3]++;
      end
      for (i = 7; i > 0; i--) dry_hist[i] = dry_hist[i-1];
      dry_hist[0] = x;
      wet = clip((corr * mix_q) >>> 15, AccW);
      if (ce == 4) begin
        taps[0] = taps[4];
        taps[2] = (taps[0] + wet) >>> 1;
        taps[1] = (taps[0] + taps[2]) >>> 1;
        taps[3] = (taps[2] + wet) >>> 1;
        taps[4] = wet;
      end else if (ce == 3) begin
        // The first in-between word reads the two-thirds point.
        taps[0] = taps[3];
        taps[2] = third_floor(taps[0] + taps[0] + wet);
        taps[1] = third_floor(taps[0] + wet + wet);
        taps[3] = wet;
      end else if (ce == 2) begin
        taps[0] = taps[2];
        taps[1] = (taps[0] + wet) >>> 1;
        taps[2] = wet;
      end else begin
        taps[0] = wet;
      end
      ovs_pos = 0;
      y = taps[0];
    end else begin
      y = taps[ovs_pos & 7];
    end
    if (ce >= 4) begin v = y; y = (y + taps[7]) >>> 1; taps[7] = v; end
    if (ce >= 3) begin v = y; y = (y + taps[6]) >>> 1; taps[6] = v; end
    if (ce >= 2) begin v = y; y = (y + taps[5]) >>> 1; taps[5] = v; end
    return SampleW'(clip(y + x, SampleW));
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: follows register writes and accepted words, checks results.
  // Everything here samples values from before the edge, so the order of
  // processes at the edge does not matter.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [SampleW-1:0] want;
    if (rst_n) begin
      if (cfg_we) model_write(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0d", $time,
                   out_result_sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_result_sample !== want) begin
            $display("%0t: result_sample mismatch, expected %0d, actual %0d",
                     $time, want, out_result_sample);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = filter_step(in_sample);
        if (in_has_typed) want = in_typed;
        expected_samples.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: ready stretches alternate with stalls of random length. Some
  // ready stretches are long, so there are spans with no stall at all.
  // ---------------------------------------------------------------------
  int ready_run;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      ready_run <= 4;
    end else if (ready_run == 0) begin
      out_ready <= !out_ready;
      ready_run <= out_ready ? $urandom_range(1, 12) : $urandom_range(1, 80);
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sender.
  // ---------------------------------------------------------------------
  typedef struct {
    logic signed [SampleW-1:0] sample;
    bit                        typed;
    logic signed [SampleW-1:0] result;
  } stim_row_t;

  localparam int DirRows = 22;
  stim_row_t dir_rows[DirRows];
  int        burst_left;

  // Drives one word and returns right after the edge that accepted it.
  // Valid stays high into the next word unless a gap is due.
  task automatic send_word(input logic signed [SampleW-1:0] s, input bit typed,
                           input logic signed [SampleW-1:0] res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_has_typed <= typed;
    in_typed     <= res;
    // In_ready may follow out_ready combinationally; both are settled at the
    // falling edge.
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Waits until every expected word has come back and the block is at rest.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  // One write; cfg_we is dropped again before the task returns, so writes never overlap.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Gains lean toward the quiet threshold and the extremes.
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'(3);
      2: return -16'(3);
      3: return 16'(4);
      4: return -16'(4);
      5: return 16'h7fff;
      6: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_gains();
    return {pick_gain(), pick_gain(), pick_gain(), pick_gain()};
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 64)) - 24'sd32;
      3: return 24'sd0;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int ph, n, items;
    logic [16:0] mix;
    logic [2:0]  ovs;

    errors       = 0;
    burst_left   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_has_typed = 1'b0;
    in_typed     = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_GAINS_LO;
    cfg_data     = '0;
    model_clear();

    // After reset every band is quiet, so the dry word comes straight back.
    dir_rows[0]  = '{24'sd0,        1, 24'sd0};
    dir_rows[1]  = '{24'sh7fffff,   1, 24'sh7fffff};
    dir_rows[2]  = '{24'sh800000,   1, 24'sh800000};
    dir_rows[3]  = '{-24'sd1,       1, -24'sd1};
    dir_rows[4]  = '{24'sd1,        1, 24'sd1};
    dir_rows[5]  = '{24'sh555555,   1, 24'sh555555};
    dir_rows[6]  = '{24'shaaaaaa,   1, 24'shaaaaaa};
    dir_rows[7]  = '{24'sh400000,   1, 24'sh400000};
    // The rest runs with loud and quiet bands and is checked by prediction.
    dir_rows[8]  = '{24'sh7fffff,   0, 24'sd0};
    dir_rows[9]  = '{24'sh800000,   0, 24'sd0};
    dir_rows[10] = '{24'sh7fffff,   0, 24'sd0};
    dir_rows[11] = '{24'sh800000,   0, 24'sd0};
    dir_rows[12] = '{24'sd0,        0, 24'sd0};
    dir_rows[13] = '{24'sd0,        0, 24'sd0};
    dir_rows[14] = '{24'sh7fffff,   0, 24'sd0};
    dir_rows[15] = '{24'sh7fffff,   0, 24'sd0};
    dir_rows[16] = '{24'sh800000,   0, 24'sd0};
    dir_rows[17] = '{24'sh123456,   0, 24'sd0};
    dir_rows[18] = '{24'shedcba9,   0, 24'sd0};
    dir_rows[19] = '{24'sh800000,   0, 24'sd0};
    dir_rows[20] = '{24'sh7fffff,   0, 24'sd0};
    dir_rows[21] = '{24'sd0,        0, 24'sd0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DirRows; r++) begin
      if (r == 8) begin
        drain();
        // Full-scale gains, a negative full mix and a period of three; the
        // lanes at magnitude three stay quiet, those at four run.
        write_reg(REG_GAINS_LO, {16'h7fff, 16'h8000, 16'h0004, 16'hfffc});
        write_reg(REG_GAINS_HI, {16'h0003, 16'hfffd, 16'h7fff, 16'h8001});
        write_reg(REG_WET_MIX, 64'h18000);
        write_reg(REG_OVS, 64'd3);
      end
      if (r == 15) begin
        drain();
        // A factor above four behaves as four.
        write_reg(REG_WET_MIX, 64'h08000);
        write_reg(REG_OVS, 64'd7);
      end
      send_word(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].result);
    end

    // Random part: each phase picks a fresh setting, the extremes included.
    for (ph = 0; ph < 12; ph++) begin
      drain();
      case (ph % 4)
        0: mix = 17'h08000;
        1: mix = 17'h18000;
        2: mix = 17'h00000;
        default: mix = 17'($urandom);
      endcase
      case (ph)
        0: ovs = 3'd0;
        1: ovs = 3'd4;
        2: ovs = 3'd1;
        3: ovs = 3'd2;
        4: ovs = 3'd5;
        default: ovs = 3'($urandom_range(1, 4));
      endcase
      write_reg(REG_GAINS_LO, ph == 11 ? 64'h8000_8000_8000_8000 : pick_gains());
      write_reg(REG_GAINS_HI, ph == 11 ? 64'h7fff_7fff_7fff_7fff : pick_gains());
      write_reg(REG_WET_MIX, {47'd0, mix});
      write_reg(REG_OVS, {61'd0, ovs});
      // Odd counts leave the oversample phase midway into the next phase.
      items = 95 + $urandom_range(0, 10);
      for (n = 0; n < items; n++) send_word(pick_sample(), 1'b0, '0);
    end

    drain();
    if (errors == 0) begin
      $display("PASS multiband_air_energy_filter_core");
    end else begin
      $display("FAIL multiband_air_energy_filter_core");
    end
    $finish;
  end

  // Watchdog well above the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL multiband_air_energy_filter_core");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/maef_pkg.sv
rtl/maef_mac.sv
rtl/multiband_air_energy_filter_core.sv
test/multiband_air_energy_filter_core_tb.sv
